>>> hw/rtl/ptqa_pkg.sv
// Package for the priority task queue with worker affinity.
// Holds the stored entry and result types, field widths, status and register codes.
// No dependencies.
package ptqa_pkg;

  localparam int WORKER_COUNT = 16;
  localparam int LEVEL_COUNT  = 16;

  localparam int TAG_W    = 16;
  localparam int LEVEL_W  = 4;
  localparam int WORKER_W = 16;
  localparam int REQ_W    = 4;
  localparam int PRIO_W   = 4;
  localparam int STATUS_W = 3;

  localparam logic [WORKER_W-1:0] WORKER_MASK = WORKER_W'((64'd1 << WORKER_COUNT) - 64'd1);

  localparam logic signed [PRIO_W-1:0] RESET_LOWEST  = -4'sd5;
  localparam logic signed [PRIO_W-1:0] RESET_HIGHEST = 4'sd5;

  // Register indexes on the configuration port.
  localparam logic REG_LOWEST  = 1'b0;
  localparam logic REG_HIGHEST = 1'b1;

  // Kinds of input words.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PUSHED        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL          = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PRIORITY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_GIVEN         = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY         = 3'd4;
  localparam logic [STATUS_W-1:0] ST_WAITING       = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NONE_ELIGIBLE = 3'd6;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [LEVEL_W-1:0]  level;
    logic [WORKER_W-1:0] mask;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    given;
    logic                wake;
    logic [REQ_W-1:0]    woken;
    logic [WORKER_W-1:0] released;
  } result_t;

endpackage

>>> hw/rtl/ptqa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptqa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/priority_task_queue_affinity_top.sv
// Top level of the priority task queue with worker affinity.
// Depends on ptqa_pkg and ptqa_ram.
//
// Usage: an input word (kind, task_tag, task_priority, eligible_workers, requester)
// is taken when in_valid is high and in_stall is low; each word yields exactly one
// result word (status, given_task, wake_valid, woken_worker, released_workers),
// taken when out_valid is high and out_stall is low. The two priority bounds are
// written over the APB port (lowest at 0x0, highest at 0x4); the user must do so only
// while the block is idle, as the block itself does not enforce it. A push, and a
// pop answered without a scan, goes from the idle state through the emit state to the
// output register. A pop on a non-empty queue sweeps all stored entries through the
// single read port of the entry RAM in the scan state; when it hands out an entry,
// the shift state moves each younger entry down one place, and then the emit state
// offers the result. in_stall is high while a word is in work; the next word can be
// taken in the cycle in which a result is offered. A word that finishes while the
// receiver stalls an earlier result holds in its last step until the output register
// frees up.
// Reset clears the queue (fill count zero), the waiting set and the output valid,
// and loads the bounds -5 and +5. No clearing pass is needed.
module priority_task_queue_affinity_top #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   kind,
  input  logic [ptqa_pkg::TAG_W-1:0]             task_tag,
  input  logic signed [ptqa_pkg::PRIO_W-1:0]     task_priority,
  input  logic [ptqa_pkg::WORKER_W-1:0]          eligible_workers,
  input  logic [ptqa_pkg::REQ_W-1:0]             requester,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [ptqa_pkg::STATUS_W-1:0]          status,
  output logic [ptqa_pkg::TAG_W-1:0]             given_task,
  output logic                                   wake_valid,
  output logic [ptqa_pkg::REQ_W-1:0]             woken_worker,
  output logic [ptqa_pkg::WORKER_W-1:0]          released_workers
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int IdxW = $clog2(QUEUE_DEPTH);
  localparam int EntW = $bits(ptqa_pkg::entry_t);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]                          state;
  logic signed [ptqa_pkg::PRIO_W-1:0]  lowest;
  logic signed [ptqa_pkg::PRIO_W-1:0]  highest;
  logic [CntW-1:0]                     count;
  logic [ptqa_pkg::WORKER_W-1:0]       waiting;
  logic [ptqa_pkg::REQ_W-1:0]          op_req;
  logic [CntW-1:0]                     scan_i;
  logic                                got;
  logic                                skipped;
  logic [ptqa_pkg::LEVEL_W-1:0]        best_lvl;
  logic [CntW-1:0]                     best_idx;
  logic [ptqa_pkg::TAG_W-1:0]          best_task;
  logic [CntW-1:0]                     wptr;
  logic                                pend;
  ptqa_pkg::result_t                   res;
  ptqa_pkg::result_t                   out_res;

  // Combinational helpers.
  logic                                accept;
  logic                                cfg_write;
  logic signed [ptqa_pkg::PRIO_W:0]    prio_diff;
  logic signed [ptqa_pkg::PRIO_W:0]    top_diff;
  logic signed [ptqa_pkg::PRIO_W+1:0]  top_lvl;
  logic                                bad_prio;
  logic                                is_full;
  logic                                push_ok;
  logic                                start_scan;
  ptqa_pkg::result_t                   idle_res;
  logic [ptqa_pkg::WORKER_W-1:0]       elig_in;
  logic [ptqa_pkg::WORKER_W-1:0]       cand;
  logic [ptqa_pkg::REQ_W-1:0]          wake_idx;
  logic [ptqa_pkg::WORKER_W-1:0]       self_bit;
  logic                                in_view;
  logic                                may_run;
  logic                                eval;
  logic                                got_next;
  logic                                skipped_next;
  logic [ptqa_pkg::LEVEL_W-1:0]        best_lvl_next;
  logic [CntW-1:0]                     best_idx_next;
  logic [ptqa_pkg::TAG_W-1:0]          best_task_next;
  logic                                shift_done;
  logic [CntW:0]                       shift_addr;

  logic                                ram_we;
  logic [IdxW-1:0]                     ram_waddr;
  logic [IdxW-1:0]                     ram_raddr;
  ptqa_pkg::entry_t                    wr_entry;
  ptqa_pkg::entry_t                    rd_entry;

  ptqa_ram #(
    .WIDTH (EntW),
    .DEPTH (QUEUE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    unique case (paddr[2])
      ptqa_pkg::REG_LOWEST:  prdata = {{(32 - ptqa_pkg::PRIO_W){1'b0}}, lowest};
      ptqa_pkg::REG_HIGHEST: prdata = {{(32 - ptqa_pkg::PRIO_W){1'b0}}, highest};
      default:               prdata = '0;
    endcase
  end

  assign status           = out_res.status;
  assign given_task       = out_res.given;
  assign wake_valid       = out_res.wake;
  assign woken_worker     = out_res.woken;
  assign released_workers = out_res.released;

  // Push checks.
  assign prio_diff = {task_priority[ptqa_pkg::PRIO_W-1], task_priority}
                   - {lowest[ptqa_pkg::PRIO_W-1], lowest};
  assign bad_prio  = (task_priority < lowest) || (task_priority > highest)
                   || (int'(prio_diff) >= ptqa_pkg::LEVEL_COUNT);
  assign is_full   = (int'(count) >= QUEUE_DEPTH);
  assign push_ok   = (kind == ptqa_pkg::KIND_PUSH) && !bad_prio && !is_full;
  assign elig_in   = eligible_workers & ptqa_pkg::WORKER_MASK;
  assign cand      = waiting & elig_in;

  // The lowest-numbered waiting worker that may run the pushed task.
  always_comb begin
    wake_idx = '0;
    for (int i = ptqa_pkg::WORKER_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        wake_idx = ptqa_pkg::REQ_W'(i);
      end
    end
  end

  // Result of a word that is answered without a scan.
  always_comb begin
    idle_res   = '0;
    start_scan = 1'b0;
    if (kind == ptqa_pkg::KIND_PUSH) begin
      if (bad_prio) begin
        idle_res.status = ptqa_pkg::ST_BAD_PRIORITY;
      end else if (is_full) begin
        idle_res.status = ptqa_pkg::ST_FULL;
      end else begin
        idle_res.status = ptqa_pkg::ST_PUSHED;
        if (cand != '0) begin
          idle_res.wake  = 1'b1;
          idle_res.woken = wake_idx;
        end
      end
    end else if (count == '0) begin
      idle_res.status = ptqa_pkg::ST_EMPTY;
    end else if (int'(requester) >= ptqa_pkg::WORKER_COUNT) begin
      idle_res.status = ptqa_pkg::ST_NONE_ELIGIBLE;
    end else if (waiting[requester]) begin
      idle_res.status = ptqa_pkg::ST_WAITING;
    end else begin
      start_scan = 1'b1;
    end
  end

  // Highest level a pop looks at; negative when the range is crossed.
  assign top_diff = {highest[ptqa_pkg::PRIO_W-1], highest} - {lowest[ptqa_pkg::PRIO_W-1], lowest};
  always_comb begin
    if (int'(top_diff) > ptqa_pkg::LEVEL_COUNT - 1) begin
      top_lvl = (ptqa_pkg::PRIO_W + 2)'(ptqa_pkg::LEVEL_COUNT - 1);
    end else begin
      top_lvl = {top_diff[ptqa_pkg::PRIO_W], top_diff};
    end
  end

  // Scan step: the RAM returns the entry at scan_i - 1 in this cycle.
  assign self_bit = ptqa_pkg::WORKER_W'(1) << op_req;
  assign eval     = (scan_i != '0);
  assign in_view  = $signed({2'b00, rd_entry.level}) <= top_lvl;
  assign may_run  = rd_entry.mask[op_req];

  always_comb begin
    got_next       = got;
    skipped_next   = skipped;
    best_lvl_next  = best_lvl;
    best_idx_next  = best_idx;
    best_task_next = best_task;
    if (eval && in_view) begin
      if (may_run) begin
        // A strictly higher level wins; within a level the oldest entry stays.
        if (!got || (rd_entry.level > best_lvl)) begin
          got_next       = 1'b1;
          best_lvl_next  = rd_entry.level;
          best_idx_next  = scan_i - CntW'(1);
          best_task_next = rd_entry.tag;
        end
      end else begin
        skipped_next = 1'b1;
      end
    end
  end

  assign shift_done = ({1'b0, wptr} + (CntW + 1)'(1)) >= {1'b0, count};
  assign shift_addr = {1'b0, wptr} + (pend ? (CntW + 1)'(2) : (CntW + 1)'(1));

  always_comb begin
    ram_we             = 1'b0;
    ram_waddr          = count[IdxW-1:0];
    ram_raddr          = scan_i[IdxW-1:0];
    wr_entry.tag       = task_tag;
    wr_entry.level     = prio_diff[ptqa_pkg::LEVEL_W-1:0];
    wr_entry.mask      = elig_in;
    unique case (state)
      S_IDLE: begin
        ram_we = accept && push_ok;
      end
      S_SHIFT: begin
        ram_raddr = shift_addr[IdxW-1:0];
        if (!shift_done && pend) begin
          ram_we    = 1'b1;
          ram_waddr = wptr[IdxW-1:0];
          wr_entry  = rd_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lowest    <= ptqa_pkg::RESET_LOWEST;
      highest   <= ptqa_pkg::RESET_HIGHEST;
      count     <= '0;
      waiting   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[2])
          ptqa_pkg::REG_LOWEST:  lowest  <= pwdata[ptqa_pkg::PRIO_W-1:0];
          ptqa_pkg::REG_HIGHEST: highest <= pwdata[ptqa_pkg::PRIO_W-1:0];
          default: begin
          end
        endcase
      end

      if ((state == S_EMIT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res     <= idle_res;
            op_req  <= requester;
            scan_i  <= '0;
            got     <= 1'b0;
            skipped <= 1'b0;
            state   <= start_scan ? S_SCAN : S_EMIT;
            if (push_ok) begin
              count <= count + CntW'(1);
              if (cand != '0) begin
                waiting[wake_idx] <= 1'b0;
              end
            end
          end
        end

        S_SCAN: begin
          got       <= got_next;
          skipped   <= skipped_next;
          best_lvl  <= best_lvl_next;
          best_idx  <= best_idx_next;
          best_task <= best_task_next;
          if (scan_i == count) begin
            if (got_next) begin
              res.status <= ptqa_pkg::ST_GIVEN;
              res.given  <= best_task_next;
              wptr       <= best_idx_next;
              pend       <= 1'b0;
              state      <= S_SHIFT;
            end else begin
              res.status <= ptqa_pkg::ST_NONE_ELIGIBLE;
              if (skipped_next) begin
                res.released <= waiting & ~self_bit;
                waiting      <= self_bit;
              end else begin
                waiting <= waiting | self_bit;
              end
              state <= S_EMIT;
            end
          end else begin
            scan_i <= scan_i + CntW'(1);
          end
        end

        S_SHIFT: begin
          // Each younger entry moves down one place; the read runs one ahead.
          if (shift_done) begin
            count <= count - CntW'(1);
            state <= S_EMIT;
          end else if (!pend) begin
            pend <= 1'b1;
          end else begin
            wptr <= wptr + CntW'(1);
          end
        end

        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_res <= res;
            state   <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
